[design/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg: shared types and helpers for the JSON string escaper
// Controller states, command/status bundles, byte classification and the
// character lookups used by the controller and the datapath.
// ----------------------------------------------------------------------------
package jse_pkg;

    // request kinds carried on the input tuser
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_NULL  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // ASCII characters produced directly by the controller
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5c;
    localparam logic [6:0] CH_U      = 7'h75;
    localparam logic [6:0] CH_N      = 7'h6e;
    localparam logic [6:0] CH_L      = 7'h6c;

    // last character index of each multi-character sequence
    localparam logic [2:0] U16_LAST   = 3'd5;
    localparam logic [2:0] SHORT_LAST = 3'd1;
    localparam logic [2:0] NULL_LAST  = 3'd3;
    localparam logic [2:0] EMPTY_LAST = 3'd1;

    localparam logic [15:0] REPL_CHAR = 16'hfffd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN,
        ST_BODY,
        ST_FLUSH_BODY,
        ST_FLUSH_LAST,
        ST_CODE,
        ST_CLOSE,
        ST_NULL,
        ST_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        CLS_SHORT,   // two-character escape
        CLS_U16,     // \u00xx escape
        CLS_PLAIN,   // printable ASCII
        CLS_LEAD,    // opens a multi-byte sequence
        CLS_BAD      // lead byte 0xfc-0xff, replacement character
    } byte_cls_t;

    typedef enum logic [1:0] {
        CODE_BMP,
        CODE_SUR,
        CODE_BIG
    } code_cls_t;

    typedef enum logic [1:0] {
        EMIT_LIT,
        EMIT_BYTE,
        EMIT_SHORT,
        EMIT_U16
    } emit_sel_t;

    typedef enum logic [2:0] {
        VAL_LEAD,
        VAL_CONT,
        VAL_BYTE,
        VAL_FFFD,
        VAL_HI,
        VAL_LO,
        VAL_BMP
    } val_sel_t;

    typedef struct packed {
        logic       load;
        logic       clear_seq;
        logic       store_cont;
        logic       open_seq;
        logic       emit;
        emit_sel_t  emit_sel;
        logic [6:0] lit;
        logic       eov;
        logic       wrap;
        val_sel_t   val_sel;
        logic       fidx_adv;
        logic       fidx_clr;
    } cmd_t;

    typedef struct packed {
        logic       seq_open;
        logic       is_cont;
        logic       will_complete;
        byte_cls_t  cls;
        logic       flush_more;
        logic       fidx_zero;
        code_cls_t  code_cls;
        logic [2:0] idx;
        logic       out_free;
        logic [1:0] in_op;
        logic       in_first;
        logic       last;
    } status_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10)
            ch = 7'h30 + {3'b000, nib};
        else
            ch = 7'h57 + {3'b000, nib};
        return ch;
    endfunction

    function automatic logic [6:0] short_char(input logic [7:0] c);
        logic [6:0] ch;
        case (c)
            8'h22:   ch = CH_QUOTE;
            8'h5c:   ch = CH_BSLASH;
            8'h08:   ch = 7'h62;
            8'h0c:   ch = 7'h66;
            8'h0a:   ch = 7'h6e;
            8'h0d:   ch = 7'h72;
            8'h09:   ch = 7'h74;
            default: ch = CH_BSLASH;
        endcase
        return ch;
    endfunction

    function automatic byte_cls_t byte_class(input logic [7:0] c);
        byte_cls_t k;
        case (c)
            8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09: k = CLS_SHORT;
            default:
            begin
                if (c < 8'h20 || c == 8'h7f || (c >= 8'h80 && c < 8'hc0))
                    k = CLS_U16;
                else if (c < 8'h80)
                    k = CLS_PLAIN;
                else if (c < 8'hfc)
                    k = CLS_LEAD;
                else
                    k = CLS_BAD;
            end
        endcase
        return k;
    endfunction

    // continuation bytes a lead byte asks for
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] n;
        if (c < 8'he0)
            n = 3'd1;
        else if (c < 8'hf0)
            n = 3'd2;
        else if (c < 8'hf8)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

endpackage

[design/jse_ctrl.sv]
// ----------------------------------------------------------------------------
// jse_ctrl: escaper sequencer
// Walks each request through opening quote, body, flush and closing quote,
// emitting at most one character per cycle into the datapath.
// ----------------------------------------------------------------------------
module jse_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  jse_pkg::status_t status,
    output jse_pkg::cmd_t    cmd
);

    jse_pkg::state_t state_reg;
    jse_pkg::state_t state_next;
    jse_pkg::state_t done_state;
    logic            accept;
    logic            u16_end;

    assign accept  = s_tvalid && (state_reg == jse_pkg::ST_IDLE);
    assign u16_end = status.out_free && (status.idx == jse_pkg::U16_LAST);

    // where a finished body byte goes
    assign done_state = status.last ? jse_pkg::ST_CLOSE : jse_pkg::ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jse_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.in_op)
                        jse_pkg::OP_BYTE:
                            state_next = status.in_first ? jse_pkg::ST_OPEN : jse_pkg::ST_BODY;
                        jse_pkg::OP_NULL:  state_next = jse_pkg::ST_NULL;
                        jse_pkg::OP_EMPTY: state_next = jse_pkg::ST_EMPTY;
                        default:           state_next = jse_pkg::ST_IDLE;
                    endcase
                end
            end
            jse_pkg::ST_OPEN:
            begin
                if (status.out_free)
                    state_next = jse_pkg::ST_BODY;
            end
            jse_pkg::ST_BODY:
            begin
                if (status.seq_open)
                begin
                    if (!status.is_cont)
                        state_next = jse_pkg::ST_FLUSH_BODY;
                    else if (status.will_complete)
                        state_next = jse_pkg::ST_CODE;
                    else
                        state_next = status.last ? jse_pkg::ST_FLUSH_LAST : jse_pkg::ST_IDLE;
                end
                else
                begin
                    case (status.cls)
                        jse_pkg::CLS_SHORT:
                        begin
                            if (status.out_free && status.idx == jse_pkg::SHORT_LAST)
                                state_next = done_state;
                        end
                        jse_pkg::CLS_U16, jse_pkg::CLS_BAD:
                        begin
                            if (u16_end)
                                state_next = done_state;
                        end
                        jse_pkg::CLS_PLAIN:
                        begin
                            if (status.out_free)
                                state_next = done_state;
                        end
                        jse_pkg::CLS_LEAD:
                            state_next = status.last ? jse_pkg::ST_FLUSH_LAST : jse_pkg::ST_IDLE;
                        default:
                            state_next = jse_pkg::ST_IDLE;
                    endcase
                end
            end
            jse_pkg::ST_FLUSH_BODY:
            begin
                if (u16_end && !status.flush_more)
                    state_next = jse_pkg::ST_BODY;
            end
            jse_pkg::ST_FLUSH_LAST:
            begin
                if (u16_end && !status.flush_more)
                    state_next = jse_pkg::ST_CLOSE;
            end
            jse_pkg::ST_CODE:
            begin
                if (u16_end && !(status.code_cls == jse_pkg::CODE_SUR && status.fidx_zero))
                    state_next = done_state;
            end
            jse_pkg::ST_CLOSE:
            begin
                if (status.out_free)
                    state_next = jse_pkg::ST_IDLE;
            end
            jse_pkg::ST_NULL:
            begin
                if (status.out_free && status.idx == jse_pkg::NULL_LAST)
                    state_next = jse_pkg::ST_IDLE;
            end
            jse_pkg::ST_EMPTY:
            begin
                if (status.out_free && status.idx == jse_pkg::EMPTY_LAST)
                    state_next = jse_pkg::ST_IDLE;
            end
            default:
                state_next = jse_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        cmd.emit_sel = jse_pkg::EMIT_LIT;
        cmd.val_sel  = jse_pkg::VAL_BYTE;
        case (state_reg)
            jse_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = accept;
            end
            jse_pkg::ST_OPEN:
            begin
                cmd.clear_seq = 1'b1;
                cmd.emit      = status.out_free;
                cmd.lit       = jse_pkg::CH_QUOTE;
                cmd.wrap      = 1'b1;
            end
            jse_pkg::ST_BODY:
            begin
                if (status.seq_open)
                begin
                    cmd.store_cont = status.is_cont;
                end
                else
                begin
                    case (status.cls)
                        jse_pkg::CLS_SHORT:
                        begin
                            cmd.emit     = status.out_free;
                            cmd.emit_sel = (status.idx == 3'd0) ? jse_pkg::EMIT_LIT
                                                                : jse_pkg::EMIT_SHORT;
                            cmd.lit      = jse_pkg::CH_BSLASH;
                            cmd.wrap     = (status.idx == jse_pkg::SHORT_LAST);
                        end
                        jse_pkg::CLS_U16:
                        begin
                            cmd.emit     = status.out_free;
                            cmd.emit_sel = jse_pkg::EMIT_U16;
                            cmd.val_sel  = jse_pkg::VAL_BYTE;
                            cmd.wrap     = (status.idx == jse_pkg::U16_LAST);
                        end
                        jse_pkg::CLS_BAD:
                        begin
                            cmd.emit     = status.out_free;
                            cmd.emit_sel = jse_pkg::EMIT_U16;
                            cmd.val_sel  = jse_pkg::VAL_FFFD;
                            cmd.wrap     = (status.idx == jse_pkg::U16_LAST);
                        end
                        jse_pkg::CLS_PLAIN:
                        begin
                            cmd.emit     = status.out_free;
                            cmd.emit_sel = jse_pkg::EMIT_BYTE;
                            cmd.wrap     = 1'b1;
                        end
                        jse_pkg::CLS_LEAD:
                            cmd.open_seq = 1'b1;
                        default:
                            cmd.open_seq = 1'b0;
                    endcase
                end
            end
            jse_pkg::ST_FLUSH_BODY, jse_pkg::ST_FLUSH_LAST:
            begin
                // lead byte first, then each buffered continuation byte
                cmd.emit     = status.out_free;
                cmd.emit_sel = jse_pkg::EMIT_U16;
                cmd.val_sel  = status.fidx_zero ? jse_pkg::VAL_LEAD : jse_pkg::VAL_CONT;
                cmd.wrap     = (status.idx == jse_pkg::U16_LAST);
                if (u16_end)
                begin
                    cmd.fidx_adv  = status.flush_more;
                    cmd.fidx_clr  = !status.flush_more;
                    cmd.clear_seq = !status.flush_more;
                end
            end
            jse_pkg::ST_CODE:
            begin
                cmd.emit     = status.out_free;
                cmd.emit_sel = jse_pkg::EMIT_U16;
                cmd.wrap     = (status.idx == jse_pkg::U16_LAST);
                case (status.code_cls)
                    jse_pkg::CODE_BMP: cmd.val_sel = jse_pkg::VAL_BMP;
                    jse_pkg::CODE_SUR:
                        cmd.val_sel = status.fidx_zero ? jse_pkg::VAL_HI : jse_pkg::VAL_LO;
                    default:           cmd.val_sel = jse_pkg::VAL_FFFD;
                endcase
                if (u16_end)
                begin
                    if (status.code_cls == jse_pkg::CODE_SUR && status.fidx_zero)
                    begin
                        cmd.fidx_adv = 1'b1;
                    end
                    else
                    begin
                        cmd.fidx_clr  = 1'b1;
                        cmd.clear_seq = 1'b1;
                    end
                end
            end
            jse_pkg::ST_CLOSE:
            begin
                cmd.emit = status.out_free;
                cmd.lit  = jse_pkg::CH_QUOTE;
                cmd.eov  = 1'b1;
                cmd.wrap = 1'b1;
            end
            jse_pkg::ST_NULL:
            begin
                cmd.clear_seq = 1'b1;
                cmd.emit      = status.out_free;
                case (status.idx)
                    3'd0:    cmd.lit = jse_pkg::CH_N;
                    3'd1:    cmd.lit = jse_pkg::CH_U;
                    default: cmd.lit = jse_pkg::CH_L;
                endcase
                cmd.eov  = (status.idx == jse_pkg::NULL_LAST);
                cmd.wrap = (status.idx == jse_pkg::NULL_LAST);
            end
            jse_pkg::ST_EMPTY:
            begin
                cmd.clear_seq = 1'b1;
                cmd.emit      = status.out_free;
                cmd.lit       = jse_pkg::CH_QUOTE;
                cmd.eov       = (status.idx == jse_pkg::EMPTY_LAST);
                cmd.wrap      = (status.idx == jse_pkg::EMPTY_LAST);
            end
            default:
                s_tready = 1'b0;
        endcase
    end

endmodule

[design/jse_datapath.sv]
// ----------------------------------------------------------------------------
// jse_datapath: escaper datapath
// Holds the request byte, the open UTF-8 sequence, the code point decode,
// the \uXXXX character generator and the output register.
// ----------------------------------------------------------------------------
module jse_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       s_tdata,
    input  logic [2:0]       s_tuser,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    input  jse_pkg::cmd_t    cmd,
    output jse_pkg::status_t status
);

    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  pend_reg [4];
    logic [2:0]  expected_reg, expected_next;
    logic [2:0]  received_reg, received_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] val_reg;
    logic [15:0] val_mux;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out_char_reg;
    logic        out_eov_reg;
    logic [6:0]  char_mux;
    logic [3:0]  nib;
    logic [2:0]  fidx_m1;
    logic [7:0]  cont_sel;
    logic [25:0] code;
    logic [20:0] code_off;
    logic [15:0] sur_hi, sur_lo;
    logic        out_free;
    logic        val_load;

    assign out_free = !out_valid_reg || m_tready;
    assign fidx_m1  = fidx_reg - 3'd1;
    assign cont_sel = pend_reg[fidx_m1[1:0]];
    assign val_load = cmd.emit && (cmd.emit_sel == jse_pkg::EMIT_U16) && (idx_reg == 3'd0);

    // code point of a complete sequence; lead mask narrows with length
    always_comb
    begin
        case (expected_reg)
            3'd1: code = {15'd0, lead_reg[4:0], pend_reg[0][5:0]};
            3'd2: code = {10'd0, lead_reg[3:0], pend_reg[0][5:0], pend_reg[1][5:0]};
            3'd3: code = {5'd0, lead_reg[2:0], pend_reg[0][5:0], pend_reg[1][5:0],
                          pend_reg[2][5:0]};
            default: code = {lead_reg[1:0], pend_reg[0][5:0], pend_reg[1][5:0],
                             pend_reg[2][5:0], pend_reg[3][5:0]};
        endcase
    end

    assign code_off = code[20:0] - 21'h10000;
    assign sur_hi   = {6'b110110, code_off[19:10]};
    assign sur_lo   = {6'b110111, code_off[9:0]};

    always_comb
    begin
        status               = '0;
        status.seq_open      = (expected_reg != 3'd0);
        status.is_cont       = (byte_reg[7:6] == 2'b10);
        status.will_complete = ({1'b0, received_reg} + 4'd1) >= {1'b0, expected_reg};
        status.cls           = jse_pkg::byte_class(byte_reg);
        status.flush_more    = (fidx_reg < received_reg);
        status.fidx_zero     = (fidx_reg == 3'd0);
        if (code < 26'h10000)
            status.code_cls = jse_pkg::CODE_BMP;
        else if (code < 26'h110000)
            status.code_cls = jse_pkg::CODE_SUR;
        else
            status.code_cls = jse_pkg::CODE_BIG;
        status.idx      = idx_reg;
        status.out_free = out_free;
        status.in_op    = s_tuser[1:0];
        status.in_first = s_tuser[2];
        status.last     = last_reg;
    end

    always_comb
    begin
        case (cmd.val_sel)
            jse_pkg::VAL_LEAD: val_mux = {8'h00, lead_reg};
            jse_pkg::VAL_CONT: val_mux = {8'h00, cont_sel};
            jse_pkg::VAL_BYTE: val_mux = {8'h00, byte_reg};
            jse_pkg::VAL_FFFD: val_mux = jse_pkg::REPL_CHAR;
            jse_pkg::VAL_HI:   val_mux = sur_hi;
            jse_pkg::VAL_LO:   val_mux = sur_lo;
            jse_pkg::VAL_BMP:  val_mux = code[15:0];
            default:           val_mux = jse_pkg::REPL_CHAR;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            3'd2:    nib = val_reg[15:12];
            3'd3:    nib = val_reg[11:8];
            3'd4:    nib = val_reg[7:4];
            default: nib = val_reg[3:0];
        endcase
        case (cmd.emit_sel)
            jse_pkg::EMIT_LIT:   char_mux = cmd.lit;
            jse_pkg::EMIT_BYTE:  char_mux = byte_reg[6:0];
            jse_pkg::EMIT_SHORT: char_mux = jse_pkg::short_char(byte_reg);
            jse_pkg::EMIT_U16:
            begin
                if (idx_reg == 3'd0)
                    char_mux = jse_pkg::CH_BSLASH;
                else if (idx_reg == 3'd1)
                    char_mux = jse_pkg::CH_U;
                else
                    char_mux = jse_pkg::hex_char(nib);
            end
            default: char_mux = cmd.lit;
        endcase
    end

    // sequence state, counters and output valid
    always_comb
    begin
        lead_next      = lead_reg;
        expected_next  = expected_reg;
        received_next  = received_reg;
        fidx_next      = fidx_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;

        if (cmd.clear_seq)
        begin
            expected_next = 3'd0;
            received_next = 3'd0;
        end
        else if (cmd.open_seq)
        begin
            lead_next     = byte_reg;
            expected_next = jse_pkg::lead_len(byte_reg);
            received_next = 3'd0;
        end
        else if (cmd.store_cont)
        begin
            received_next = received_reg + 3'd1;
        end

        if (cmd.fidx_clr)
            fidx_next = 3'd0;
        else if (cmd.fidx_adv)
            fidx_next = fidx_reg + 3'd1;

        if (cmd.emit)
            idx_next = cmd.wrap ? 3'd0 : idx_reg + 3'd1;

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= 8'h00;
            expected_reg  <= 3'd0;
            received_reg  <= 3'd0;
            fidx_reg      <= 3'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lead_reg      <= lead_next;
            expected_reg  <= expected_next;
            received_reg  <= received_next;
            fidx_reg      <= fidx_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.store_cont)
            pend_reg[received_reg[1:0]] <= byte_reg;
        if (val_load)
            val_reg <= val_mux;
        if (cmd.emit)
        begin
            out_char_reg <= char_mux;
            out_eov_reg  <= cmd.eov;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_eov_reg;

    a_recv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        received_reg <= expected_reg)
        else $error("continuation count ran past the sequence length");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("character emitted over a held output");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted character not presented");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= jse_pkg::U16_LAST)
        else $error("character index out of range");

    a_cont_read: assert property (@(posedge clk) disable iff (!rst_n)
        (val_load && cmd.val_sel == jse_pkg::VAL_CONT)
            |-> (fidx_reg != 3'd0 && fidx_reg <= received_reg))
        else $error("flush read an unwritten continuation byte");

endmodule

[design/json_string_escaper_utf8.sv]
// ----------------------------------------------------------------------------
// json_string_escaper_utf8: UTF-8 string to JSON text escaper
// Streams a string in byte by byte and streams its JSON-quoted ASCII form out.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and a new one is accepted only in the
// idle state. A printable ASCII byte gives one character, a short escape two
// and a \u00xx escape six; a byte that opens or continues a sequence without
// completing it gives none, and a continuation byte that completes a sequence
// gives one \uXXXX escape (two as a surrogate pair). The opening and closing
// quotes add one character each, a bad continuation byte is preceded by a
// \u00xx escape for every byte flushed ahead of it, and a sequence left open
// by the last byte is flushed as \u00xx escapes before the closing quote. The
// sequencer loads the single output register with one character per cycle
// while it is free; backpressure on m_tready holds it.
module json_string_escaper_utf8
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [2:0] s_tuser,   // [1:0] operation, [2] first
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast
);

    jse_pkg::cmd_t    cmd;
    jse_pkg::status_t status;

    jse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jse_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

[tb/json_string_escaper_utf8_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_test: self-checking bench for the JSON escaper
// Feeds directed table rows and then random strings of ASCII, escapes and
// UTF-8 sequences, some broken. Every output character is checked against a
// local escaper model or a directed row's typed text. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_test;

    localparam logic [1:0] OP_IGNORED = 2'd3;   // no output, no state change
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [6:0] ch;
        logic       eov;
    } json_char_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
    } str_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic [2:0] s_tuser;    // [1:0] operation, [2] first
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [6:0] out_char, [7] zero
    logic       m_tlast;

    json_string_escaper_utf8 dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // escaper model state
    logic [7:0]  utf_lead = 8'h00;
    logic [7:0]  utf_cont [4];
    int unsigned utf_need = 0;
    int unsigned utf_have = 0;

    json_char_t step_chars[$];
    json_char_t json_expected[$];

    str_row_t   dir_rows[$];
    string      dir_text[$];
    logic [7:0] str_bytes[$];

    int  errors = 0;
    int  items_sent = 0;
    int  strings_sent = 0;
    int  specials_sent = 0;
    int  ignored_sent = 0;
    int  chars_seen = 0;
    bit  no_idle = 0;
    bit  sink_hold_req = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("FAIL json_string_escaper_utf8");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void put_char(logic [7:0] ch, logic eov);
        step_chars.push_back(json_char_t'{ch[6:0], eov});
    endfunction

    function automatic void put_short(logic [7:0] ch);
        put_char(jse_pkg::CH_BSLASH, 1'b0);
        put_char(ch, 1'b0);
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + {4'h0, nib};
        else
            return "a" + {4'h0, nib} - 8'd10;
    endfunction

    function automatic void put_u16(logic [15:0] v);
        put_char(jse_pkg::CH_BSLASH, 1'b0);
        put_char(jse_pkg::CH_U, 1'b0);
        for (int s = 12; s >= 0; s -= 4)
            put_char(hex_digit(v[s +: 4]), 1'b0);
    endfunction

    function automatic void put_code(int unsigned cp);
        int unsigned off;
        if (cp < 32'h10000)
            put_u16(cp[15:0]);
        else if (cp < 32'h110000)
        begin
            off = cp - 32'h10000;
            put_u16(16'hd800 | {6'h00, off[19:10]});
            put_u16(16'hdc00 | {6'h00, off[9:0]});
        end
        else
            put_u16(jse_pkg::REPL_CHAR);
    endfunction

    function automatic void utf_drop();
        utf_need = 0;
        utf_have = 0;
    endfunction

    // open sequence goes out byte by byte as \u00xx
    function automatic void utf_flush();
        if (utf_need != 0)
        begin
            put_u16({8'h00, utf_lead});
            for (int i = 0; i < utf_have && i < 4; i++)
                put_u16({8'h00, utf_cont[i]});
        end
        utf_drop();
    endfunction

    function automatic void utf_open(logic [7:0] c, int unsigned n);
        utf_lead = c;
        utf_need = n;
        utf_have = 0;
    endfunction

    function automatic void utf_finish();
        logic [7:0]  mask;
        int unsigned cp;
        mask = 8'h7f >> (utf_need + 1);
        cp = utf_lead & mask;
        for (int i = 0; i < utf_need && i < 4; i++)
            cp = (cp << 6) | (utf_cont[i] & 8'h3f);
        utf_drop();
        put_code(cp);
    endfunction

    function automatic void escape_byte(logic [7:0] c);
        case (c)
            8'h22: put_short(jse_pkg::CH_QUOTE);
            8'h5c: put_short(jse_pkg::CH_BSLASH);
            8'h08: put_short("b");
            8'h0c: put_short("f");
            8'h0a: put_short("n");
            8'h0d: put_short("r");
            8'h09: put_short("t");
            default:
            begin
                if (c < 8'h20 || c == 8'h7f || (c >= 8'h80 && c < 8'hc0))
                    put_u16({8'h00, c});
                else if (c < 8'h80)
                    put_char(c, 1'b0);
                else if (c < 8'he0)
                    utf_open(c, 1);
                else if (c < 8'hf0)
                    utf_open(c, 2);
                else if (c < 8'hf8)
                    utf_open(c, 3);
                else if (c < 8'hfc)
                    utf_open(c, 4);
                else
                    put_u16(jse_pkg::REPL_CHAR);
            end
        endcase
    endfunction

    // characters one accepted request produces, left in step_chars
    function automatic void escape_request(logic [1:0] op, logic [7:0] c,
                                           logic is_first, logic is_last);
        step_chars.delete();
        if (op == jse_pkg::OP_NULL)
        begin
            utf_drop();
            put_char(jse_pkg::CH_N, 1'b0);
            put_char(jse_pkg::CH_U, 1'b0);
            put_char(jse_pkg::CH_L, 1'b0);
            put_char(jse_pkg::CH_L, 1'b1);
        end
        else if (op == jse_pkg::OP_EMPTY)
        begin
            utf_drop();
            put_char(jse_pkg::CH_QUOTE, 1'b0);
            put_char(jse_pkg::CH_QUOTE, 1'b1);
        end
        else if (op == jse_pkg::OP_BYTE)
        begin
            if (is_first)
            begin
                utf_drop();
                put_char(jse_pkg::CH_QUOTE, 1'b0);
            end
            if (utf_need != 0)
            begin
                if ((c & 8'hc0) == 8'h80)
                begin
                    utf_cont[utf_have % 4] = c;
                    utf_have++;
                    if (utf_have >= utf_need)
                        utf_finish();
                end
                else
                begin
                    // bad continuation: flush, then treat the byte as new
                    utf_flush();
                    escape_byte(c);
                end
            end
            else
                escape_byte(c);
            if (is_last)
            begin
                utf_flush();
                put_char(jse_pkg::CH_QUOTE, 1'b1);
            end
        end
    endfunction

    // typed text, if given, replaces the model's characters as the expectation
    task automatic send_request(input logic [1:0] op, input logic [7:0] c,
                                input logic is_first, input logic is_last,
                                input string typed);
        int         gap;
        logic [7:0] tch;
        logic       ends;
        gap = (no_idle || sink_hold_req) ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= {is_first, op};
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        escape_request(op, c, is_first, is_last);
        if (typed.len() == 0)
        begin
            foreach (step_chars[i])
                json_expected.push_back(step_chars[i]);
        end
        else
        begin
            ends = is_last || op == jse_pkg::OP_NULL || op == jse_pkg::OP_EMPTY;
            for (int i = 0; i < typed.len(); i++)
            begin
                tch = typed[i];
                json_expected.push_back(json_char_t'{tch[6:0],
                                                     ends && i == typed.len() - 1});
            end
        end
        if (op == OP_IGNORED)
            ignored_sent++;
        else
            items_sent++;
    endtask

    function automatic void add_row(logic [1:0] op, logic [7:0] c, logic f,
                                    logic l, string typed);
        dir_rows.push_back(str_row_t'{op, c, f, l});
        dir_text.push_back(typed);
    endfunction

    function automatic logic [7:0] random_lead(int n);
        case (n)
            1:       return 8'hc0 | 8'($urandom_range(0, 31));
            2:       return 8'he0 | 8'($urandom_range(0, 15));
            3:       return 8'hf0 | 8'($urandom_range(0, 7));
            default: return 8'hf8 | 8'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [7:0] random_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // one character of a random string, appended to str_bytes
    function automatic void push_random_char();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40)
            str_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        else if (r < 55)
        begin
            case ($urandom_range(0, 9))
                0:       str_bytes.push_back(8'h22);
                1:       str_bytes.push_back(8'h5c);
                2:       str_bytes.push_back(8'h08);
                3:       str_bytes.push_back(8'h0c);
                4:       str_bytes.push_back(8'h0a);
                5:       str_bytes.push_back(8'h0d);
                6:       str_bytes.push_back(8'h09);
                7:       str_bytes.push_back(8'h7f);
                default: str_bytes.push_back(8'($urandom_range(0, 31)));
            endcase
        end
        else if (r < 85)
        begin
            n = $urandom_range(1, 4);
            str_bytes.push_back(random_lead(n));
            repeat (n) str_bytes.push_back(random_cont());
        end
        else if (r < 93)
        begin
            // truncated sequence; whatever follows breaks it, unless it is a continuation byte
            n = $urandom_range(1, 4);
            str_bytes.push_back(random_lead(n));
            repeat ($urandom_range(0, n - 1)) str_bytes.push_back(random_cont());
        end
        else
            str_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // output side ready, with a long hold when asked for
    initial
    begin : sink_ready
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 0;
            end
            gap = no_idle ? 0 : gap_len();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : char_check
        json_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_seen++;
            if (json_expected.size() == 0)
            begin
                $error("unexpected character: m_tdata %h, m_tlast %b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = json_expected.pop_front();
                if (m_tdata[6:0] !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, m_tdata[6:0]);
                    errors++;
                end
                if (m_tdata[7] !== 1'b0)
                begin
                    $error("m_tdata[7]: expected 0, got %b", m_tdata[7]);
                    errors++;
                end
                if (m_tlast !== want.eov)
                begin
                    $error("end_of_value: expected %b, got %b", want.eov, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int  r;
        int  nchars;
        bit  drop_last;
        bit  hold_done;
        bit  drain_done;
        logic [1:0] op;

        hold_done  = 0;
        drain_done = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 3'b000;
        s_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: whole values, every escape class, UTF-8 corner cases
        add_row(jse_pkg::OP_NULL,  8'h00, 1'b0, 1'b0, "null");
        add_row(jse_pkg::OP_EMPTY, 8'hff, 1'b1, 1'b1, "\"\"");
        add_row(jse_pkg::OP_BYTE,  8'h41, 1'b1, 1'b1, "\"A\"");
        add_row(jse_pkg::OP_BYTE,  8'h00, 1'b1, 1'b0, "\"\\u0000");
        add_row(jse_pkg::OP_BYTE,  8'h22, 1'b0, 1'b0, "\\\"");
        add_row(jse_pkg::OP_BYTE,  8'h5c, 1'b0, 1'b0, "\\\\");
        add_row(jse_pkg::OP_BYTE,  8'h08, 1'b0, 1'b0, "\\b");
        add_row(jse_pkg::OP_BYTE,  8'h0c, 1'b0, 1'b0, "\\f");
        add_row(jse_pkg::OP_BYTE,  8'h0a, 1'b0, 1'b0, "\\n");
        add_row(jse_pkg::OP_BYTE,  8'h0d, 1'b0, 1'b0, "\\r");
        add_row(jse_pkg::OP_BYTE,  8'h09, 1'b0, 1'b0, "\\t");
        add_row(jse_pkg::OP_BYTE,  8'h7f, 1'b0, 1'b0, "\\u007f");
        add_row(jse_pkg::OP_BYTE,  8'h80, 1'b0, 1'b0, "\\u0080");
        add_row(jse_pkg::OP_BYTE,  8'hff, 1'b0, 1'b1, "\\ufffd\"");
        // four-byte sequence above the BMP: surrogate pair
        add_row(jse_pkg::OP_BYTE,  8'hf0, 1'b1, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h9f, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h98, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h80, 1'b0, 1'b0, "");
        // five-byte lead broken by plain ASCII
        add_row(jse_pkg::OP_BYTE,  8'hf8, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h88, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h80, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h80, 1'b0, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'h41, 1'b0, 1'b0, "");
        // overlong lead left open at the end of the string
        add_row(jse_pkg::OP_BYTE,  8'hc0, 1'b0, 1'b1, "");
        // first while open drops it, null request drops the next one
        add_row(jse_pkg::OP_BYTE,  8'he2, 1'b1, 1'b0, "");
        add_row(jse_pkg::OP_BYTE,  8'hc3, 1'b1, 1'b0, "");
        add_row(jse_pkg::OP_NULL,  8'hc3, 1'b0, 1'b0, "");
        add_row(OP_IGNORED, 8'h5a, 1'b1, 1'b1, "");

        for (int i = 0; i < dir_rows.size(); i++)
            send_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].is_first,
                         dir_rows[i].is_last, dir_text[i]);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= 150)
            begin
                hold_done = 1;
                sink_hold_req = 1;
            end
            if (!drain_done && items_sent >= 330)
            begin
                // let the output catch up completely before going on
                drain_done = 1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (json_expected.size() != 0)
                    @(posedge clk);
            end
            no_idle = items_sent >= 230 && items_sent < 290;

            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                op = $urandom_range(0, 1) ? jse_pkg::OP_NULL : jse_pkg::OP_EMPTY;
                send_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), "");
                specials_sent++;
            end
            else if (r < 11)
                send_request(OP_IGNORED, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), "");
            else if (r < 16)
                send_request(jse_pkg::OP_BYTE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), "");
            else
            begin
                str_bytes.delete();
                nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(1, 6);
                repeat (nchars) push_random_char();
                drop_last = $urandom_range(0, 19) == 0;
                for (int i = 0; i < str_bytes.size(); i++)
                    send_request(jse_pkg::OP_BYTE, str_bytes[i], i == 0,
                                 i == str_bytes.size() - 1 && !drop_last, "");
                strings_sent++;
            end
        end
        no_idle = 0;
        s_tvalid <= 1'b0;

        while (json_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d random requests: %0d strings, %0d null/empty, %0d ignored",
                 items_sent, strings_sent, specials_sent, ignored_sent);
        $display("Checked %0d output characters, with a %0d-cycle output hold and a drain pause",
                 chars_seen, HOLD_CYCLES);
        if (errors == 0)
            $display("PASS json_string_escaper_utf8");
        else
            $display("FAIL json_string_escaper_utf8");
        $finish;
    end

endmodule

[json_string_escaper_utf8.f]
design/jse_pkg.sv
design/jse_ctrl.sv
design/jse_datapath.sv
design/json_string_escaper_utf8.sv
tb/json_string_escaper_utf8_test.sv
